FILE: design/assert_macros.svh
// assertion macros shared by the block fifo rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: design/bfl_pkg.sv
// package of the block fifo: sizes, codes, types and ring pointer helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bfl_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int SLOT_BYTES  = 64;
    localparam int MAX_LEN     = SLOT_BYTES - 2;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int FILL_W      = $clog2(SLOT_BYTES);
    localparam int BYTE_DEPTH  = SLOT_COUNT * (2 ** FILL_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int FREE_W      = 4;
    localparam int LEN_OUT_W   = 6;

    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [SLOT_W:0]      slot_ext_t;
    typedef logic [FILL_W-1:0]    idx_t;
    typedef logic [FREE_W-1:0]    free_t;
    typedef logic [LEN_OUT_W-1:0] len_out_t;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } bfl_action_t;

    typedef enum logic [1:0] {
        ST_PUSH_OK   = 2'd0,
        ST_PUSH_REJ  = 2'd1,
        ST_POP_DATA  = 2'd2,
        ST_POP_EMPTY = 2'd3
    } bfl_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LEN,
        BK_STREAM
    } bfl_back_state_t;

    // one entry of the queue between front and back
    typedef struct packed {
        logic        is_pop;
        bfl_status_t status;
        idx_t        len;
        free_t       free;
        slot_t       slot;
    } bfl_cmd_t;

    // front side write port of both stores
    typedef struct packed {
        logic       byte_en;
        logic       len_en;
        slot_t      slot;
        idx_t       idx;
        logic [7:0] data;
        idx_t       len;
    } bfl_wr_t;

    // back side read port of both stores
    typedef struct packed {
        logic  byte_en;
        logic  len_en;
        slot_t slot;
        idx_t  idx;
    } bfl_rd_t;

    function automatic slot_t next_slot(slot_t s);
        return (s == slot_t'(SLOT_COUNT - 1)) ? '0 : s + slot_t'(1);
    endfunction

    // (SLOT_COUNT-1+rd-wr) mod SLOT_COUNT, kept to FREE_W bits
    function automatic free_t free_slots_calc(slot_t rd, slot_t wr);
        slot_ext_t t;
        t = {1'b0, rd} + slot_ext_t'(SLOT_COUNT - 1) - {1'b0, wr};
        if (t >= slot_ext_t'(SLOT_COUNT))
        begin
            t = t - slot_ext_t'(SLOT_COUNT);
        end
        return free_t'(t);
    endfunction

endpackage

`default_nettype wire

FILE: design/bfl_if.sv
// request and response channel interfaces of the block fifo
// valid/ready handshake, no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface bfl_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, action, data_byte, last_byte, input ready);
    modport sink   (input valid, action, data_byte, last_byte, output ready);
endinterface

interface bfl_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] out_byte;
    logic       run_last;
    logic [5:0] block_length;
    logic [3:0] free_slots;

    modport source (output valid, status, out_byte, run_last, block_length, free_slots,
                    input ready);
    modport sink   (input valid, status, out_byte, run_last, block_length, free_slots,
                    output ready);
endinterface

`default_nettype wire

FILE: design/block_fifo_with_length_unit.sv
// block fifo with length: ring of whole data blocks with a length per slot
// top level; depends on bfl_pkg, bfl_if, bfl_ram, bfl_queue, bfl_front, bfl_back
//
// req channel: one transaction per pushed byte (action push, data_byte, last_byte)
// or one per pop request. rsp channel: one result per finished push (accept or
// reject), one per popped byte, or one for a pop on an empty ring.
// throughput: push bytes are taken one per cycle while req.ready is high. a
// pop streams its block one byte per cycle while rsp.ready is high; while the
// block is being read out of the byte ram the request side holds ready low.
// result path: a push result passes the command queue and the response register
// after its last byte is taken; the first byte of a pop passes the queue, the
// length read, the byte read and the response register after the pop is taken.
// reset clears the ring pointers, the fill state and all valid flags; the ring
// is empty at once and no clearing pass runs, the stores hold unknown data
// until written.
// when the receiver stalls, the response register and the byte ram output hold
// their data, the command queue fills and then req.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module block_fifo_with_length_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    bfl_req_if.sink   req,
    bfl_rsp_if.source rsp
);

    logic              enq;
    bfl_pkg::bfl_cmd_t enq_cmd;
    logic              q_full;
    logic              deq;
    bfl_pkg::bfl_cmd_t head;
    logic              head_valid;
    logic              pop_done;
    bfl_pkg::bfl_wr_t  wr;
    bfl_pkg::bfl_rd_t  rd;
    logic [7:0]        byte_rdata;
    bfl_pkg::idx_t     len_rdata;

    bfl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .enq      (enq),
        .enq_cmd  (enq_cmd),
        .q_full   (q_full),
        .pop_done (pop_done),
        .wr       (wr)
    );

    bfl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (enq),
        .wdata      (enq_cmd),
        .full       (q_full),
        .pop        (deq),
        .head       (head),
        .head_valid (head_valid)
    );

    bfl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rsp        (rsp),
        .head       (head),
        .head_valid (head_valid),
        .deq        (deq),
        .rd         (rd),
        .byte_rdata (byte_rdata),
        .len_rdata  (len_rdata),
        .pop_done   (pop_done)
    );

    // byte store, addressed as slot and byte index
    bfl_ram #(
        .WIDTH (8),
        .DEPTH (bfl_pkg::BYTE_DEPTH)
    ) u_byte_ram (
        .clk   (clk),
        .we    (wr.byte_en),
        .waddr ({wr.slot, wr.idx}),
        .wdata (wr.data),
        .re    (rd.byte_en),
        .raddr ({rd.slot, rd.idx}),
        .rdata (byte_rdata)
    );

    bfl_ram #(
        .WIDTH (bfl_pkg::FILL_W),
        .DEPTH (bfl_pkg::SLOT_COUNT)
    ) u_len_ram (
        .clk   (clk),
        .we    (wr.len_en),
        .waddr (wr.slot),
        .wdata (wr.len),
        .re    (rd.len_en),
        .raddr (rd.slot),
        .rdata (len_rdata)
    );

endmodule

`default_nettype wire

FILE: design/bfl_ram.sv
// generic simple dual port ram, one write and one registered read port
// read data holds while the read enable is low
`timescale 1ns / 1ps
`default_nettype none

module bfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/bfl_queue.sv
// short command queue between the front and the back of the block fifo
// depends on bfl_pkg
`timescale 1ns / 1ps
`default_nettype none

module bfl_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire bfl_pkg::bfl_cmd_t wdata,
    output logic                  full,
    input  wire logic             pop,
    output bfl_pkg::bfl_cmd_t     head,
    output logic                  head_valid
);

    localparam int PTR_W = (bfl_pkg::QUEUE_DEPTH > 1) ? $clog2(bfl_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(bfl_pkg::QUEUE_DEPTH + 1);

    bfl_pkg::bfl_cmd_t  entry_reg [bfl_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wptr_reg;
    logic [PTR_W-1:0]   wptr_next;
    logic [PTR_W-1:0]   rptr_reg;
    logic [PTR_W-1:0]   rptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(bfl_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full       = (count_reg == CNT_W'(bfl_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? ptr_inc(wptr_reg) : wptr_reg;
        rptr_next  = pop ? ptr_inc(rptr_reg) : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: design/bfl_front.sv
// front of the block fifo: takes request transactions, fills slots,
// keeps the ring pointers and queues results and pop commands; uses bfl_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bfl_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    bfl_req_if.sink                req,
    output logic                   enq,
    output bfl_pkg::bfl_cmd_t      enq_cmd,
    input  wire logic              q_full,
    input  wire logic              pop_done,
    output bfl_pkg::bfl_wr_t       wr
);

    bfl_pkg::slot_t wslot_reg;
    bfl_pkg::slot_t wslot_next;
    bfl_pkg::slot_t rslot_reg;
    bfl_pkg::slot_t rslot_next;
    bfl_pkg::idx_t  fill_reg;
    bfl_pkg::idx_t  fill_next;
    logic           too_long_reg;
    logic           too_long_next;
    logic           pop_busy_reg;
    logic           pop_busy_next;
    logic           accept;
    logic           reject;

    // the ring is frozen while a pop is being read out
    assign req.ready = !pop_busy_reg && !q_full;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        wslot_next    = wslot_reg;
        rslot_next    = rslot_reg;
        fill_next     = fill_reg;
        too_long_next = too_long_reg;
        pop_busy_next = pop_busy_reg;
        enq           = 1'b0;
        enq_cmd       = '0;
        wr.byte_en    = 1'b0;
        wr.len_en     = 1'b0;
        wr.slot       = wslot_reg;
        wr.idx        = fill_reg;
        wr.data       = req.data_byte;
        wr.len        = fill_reg + bfl_pkg::idx_t'(1);
        reject        = too_long_reg || (fill_reg >= bfl_pkg::idx_t'(bfl_pkg::MAX_LEN))
                        || (bfl_pkg::next_slot(wslot_reg) == rslot_reg);

        if (pop_done)
        begin
            pop_busy_next = 1'b0;
        end

        if (accept)
        begin
            if (req.action == bfl_pkg::ACT_PUSH)
            begin
                if (!req.last_byte)
                begin
                    if (fill_reg < bfl_pkg::idx_t'(bfl_pkg::MAX_LEN))
                    begin
                        wr.byte_en = 1'b1;
                        fill_next  = fill_reg + bfl_pkg::idx_t'(1);
                    end
                    else
                    begin
                        too_long_next = 1'b1;
                    end
                end
                else
                begin
                    fill_next     = '0;
                    too_long_next = 1'b0;
                    enq           = 1'b1;
                    if (reject)
                    begin
                        enq_cmd.status = bfl_pkg::ST_PUSH_REJ;
                        enq_cmd.free   = bfl_pkg::free_slots_calc(rslot_reg, wslot_reg);
                    end
                    else
                    begin
                        wr.byte_en     = 1'b1;
                        wr.len_en      = 1'b1;
                        wslot_next     = bfl_pkg::next_slot(wslot_reg);
                        enq_cmd.status = bfl_pkg::ST_PUSH_OK;
                        enq_cmd.len    = fill_reg + bfl_pkg::idx_t'(1);
                        enq_cmd.free   = bfl_pkg::free_slots_calc(rslot_reg, wslot_next);
                    end
                end
            end
            else
            begin
                enq = 1'b1;
                if (rslot_reg == wslot_reg)
                begin
                    enq_cmd.status = bfl_pkg::ST_POP_EMPTY;
                    enq_cmd.free   = bfl_pkg::free_slots_calc(rslot_reg, wslot_reg);
                end
                else
                begin
                    rslot_next     = bfl_pkg::next_slot(rslot_reg);
                    pop_busy_next  = 1'b1;
                    enq_cmd.is_pop = 1'b1;
                    enq_cmd.status = bfl_pkg::ST_POP_DATA;
                    enq_cmd.slot   = rslot_reg;
                    enq_cmd.free   = bfl_pkg::free_slots_calc(rslot_next, wslot_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wslot_reg    <= '0;
            rslot_reg    <= '0;
            fill_reg     <= '0;
            too_long_reg <= 1'b0;
            pop_busy_reg <= 1'b0;
        end
        else
        begin
            wslot_reg    <= wslot_next;
            rslot_reg    <= rslot_next;
            fill_reg     <= fill_next;
            too_long_reg <= too_long_next;
            pop_busy_reg <= pop_busy_next;
        end
    end

    `ASSERT_NEVER(a_no_accept_while_popping, pop_busy_reg && accept, "transaction taken during pop")
    `ASSERT_ALWAYS(a_fill_bounded, fill_reg <= bfl_pkg::idx_t'(bfl_pkg::MAX_LEN), "fill overrun")
    `ASSERT_NEVER(a_enq_when_full, enq && q_full, "command queue overflow")

endmodule

`default_nettype wire

FILE: design/bfl_back.sv
// back of the block fifo: drains the command queue, reads popped blocks
// out of the byte store and drives the response register; uses bfl_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bfl_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    bfl_rsp_if.source              rsp,
    input  wire bfl_pkg::bfl_cmd_t head,
    input  wire logic              head_valid,
    output logic                   deq,
    output bfl_pkg::bfl_rd_t       rd,
    input  wire logic [7:0]        byte_rdata,
    input  wire bfl_pkg::idx_t     len_rdata,
    output logic                   pop_done
);

    bfl_pkg::bfl_back_state_t state_reg;
    bfl_pkg::bfl_back_state_t state_next;
    bfl_pkg::slot_t           slot_reg;
    bfl_pkg::slot_t           slot_next;
    bfl_pkg::free_t           free_reg;
    bfl_pkg::free_t           free_next;
    bfl_pkg::idx_t            len_reg;
    bfl_pkg::idx_t            len_next;
    bfl_pkg::idx_t            idx_reg;
    bfl_pkg::idx_t            idx_next;
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic                     s1_last_reg;
    logic                     s1_last_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    bfl_pkg::bfl_status_t     out_status_reg;
    bfl_pkg::bfl_status_t     out_status_next;
    logic [7:0]               out_byte_reg;
    logic [7:0]               out_byte_next;
    logic                     out_last_reg;
    logic                     out_last_next;
    bfl_pkg::len_out_t        out_len_reg;
    bfl_pkg::len_out_t        out_len_next;
    bfl_pkg::free_t           out_free_reg;
    bfl_pkg::free_t           out_free_next;
    logic                     out_load;
    logic                     s1_move;
    logic                     issue;
    logic                     last_idx;

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.out_byte     = out_byte_reg;
    assign rsp.run_last     = out_last_reg;
    assign rsp.block_length = out_len_reg;
    assign rsp.free_slots   = out_free_reg;

    // s1 is the byte ram output register, out is the response register
    assign out_load = !out_valid_reg || rsp.ready;
    assign s1_move  = s1_valid_reg && out_load;
    assign issue    = (state_reg == bfl_pkg::BK_STREAM) && (!s1_valid_reg || s1_move);
    assign last_idx = (idx_reg + bfl_pkg::idx_t'(1)) == len_reg;

    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        free_next     = free_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        s1_last_next  = s1_last_reg;
        deq           = 1'b0;
        pop_done      = 1'b0;
        rd.byte_en    = issue;
        rd.len_en     = 1'b0;
        rd.slot       = slot_reg;
        rd.idx        = idx_reg;

        unique case (state_reg)
            bfl_pkg::BK_IDLE:
            begin
                // wait for the last popped byte to leave s1 before the next command
                if (head_valid && !s1_valid_reg)
                begin
                    if (head.is_pop)
                    begin
                        deq        = 1'b1;
                        rd.len_en  = 1'b1;
                        rd.slot    = head.slot;
                        slot_next  = head.slot;
                        free_next  = head.free;
                        state_next = bfl_pkg::BK_LEN;
                    end
                    else if (out_load)
                    begin
                        deq = 1'b1;
                    end
                end
            end
            bfl_pkg::BK_LEN:
            begin
                len_next   = len_rdata;
                idx_next   = '0;
                state_next = bfl_pkg::BK_STREAM;
            end
            bfl_pkg::BK_STREAM:
            begin
                if (issue)
                begin
                    idx_next     = idx_reg + bfl_pkg::idx_t'(1);
                    s1_last_next = last_idx;
                    if (last_idx)
                    begin
                        pop_done   = 1'b1;
                        state_next = bfl_pkg::BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = bfl_pkg::BK_IDLE;
            end
        endcase

        s1_valid_next = s1_valid_reg;
        if (issue)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_len_next    = out_len_reg;
        out_free_next   = out_free_reg;
        priority if (s1_move)
        begin
            out_valid_next  = 1'b1;
            out_status_next = bfl_pkg::ST_POP_DATA;
            out_byte_next   = byte_rdata;
            out_last_next   = s1_last_reg;
            out_len_next    = bfl_pkg::len_out_t'(len_reg);
            out_free_next   = free_reg;
        end
        else if (deq && !head.is_pop)
        begin
            out_valid_next  = 1'b1;
            out_status_next = head.status;
            out_byte_next   = '0;
            out_last_next   = 1'b1;
            out_len_next    = bfl_pkg::len_out_t'(head.len);
            out_free_next   = head.free;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfl_pkg::BK_IDLE;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        free_reg       <= free_next;
        len_reg        <= len_next;
        idx_reg        <= idx_next;
        s1_last_reg    <= s1_last_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
        out_len_reg    <= out_len_next;
        out_free_reg   <= out_free_next;
    end

    `ASSERT_ALWAYS(a_s1_holds, s1_valid_reg && !out_load |=> s1_valid_reg && $stable(s1_last_reg), "s1 byte lost")
    `ASSERT_ALWAYS(a_done_fills_s1, pop_done |=> s1_valid_reg && s1_last_reg, "last byte missing")
    `ASSERT_NEVER(a_len_after_drain, (state_reg == bfl_pkg::BK_LEN) && s1_valid_reg, "pop started early")

endmodule

`default_nettype wire

FILE: test/testbench.sv
// testbench for block_fifo_with_length_unit: driver, monitor and a cycle-free predictor
// of the block ring; depends on bfl_pkg, bfl_if and the rtl under design/
`timescale 1ns / 1ps

module testbench;
    import bfl_pkg::*;

    localparam int HOLD_CYCLES = 300;

    typedef struct {
        bfl_action_t action;
        logic [7:0]  data;
        logic        last;
    } req_item_t;

    typedef struct {
        bfl_status_t status;
        logic [7:0]  out_byte;
        logic        run_last;
        len_out_t    block_length;
        free_t       free_slots;
    } fifo_result_t;

    logic clk;
    logic rst_n;

    bfl_req_if req_ch ();
    bfl_rsp_if rsp_ch ();

    block_fifo_with_length_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    req_item_t    pending_items[$];
    fifo_result_t expected_results[$];

    // predictor copy of the ring
    logic [7:0] ring_bytes [SLOT_COUNT][SLOT_BYTES];
    int         ring_lengths [SLOT_COUNT];
    slot_t      wr_slot = '0;
    slot_t      rd_slot = '0;
    int         gather_count = 0;
    logic       gather_overflow = 1'b0;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int holds_requested = 0;
    int holds_served;
    int hold_left;

    int errors = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int pops_seen = 0;
    int rejects_seen = 0;

    function automatic slot_t advance_slot(slot_t s);
        return (int'(s) == SLOT_COUNT - 1) ? slot_t'(0) : s + slot_t'(1);
    endfunction

    function automatic void expect_result(bfl_status_t st, logic [7:0] b, logic lst, int len);
        fifo_result_t r;
        r.status       = st;
        r.out_byte     = b;
        r.run_last     = lst;
        r.block_length = len_out_t'(len);
        r.free_slots   = free_t'((SLOT_COUNT - 1 + int'(rd_slot) - int'(wr_slot)) % SLOT_COUNT);
        expected_results.push_back(r);
    endfunction

    function automatic void predict_fifo_results(bfl_action_t act, logic [7:0] data,
                                                 logic last);
        int    len;
        int    i;
        slot_t slot;
        if (act == ACT_PUSH)
        begin
            if (!last)
            begin
                if (gather_count < MAX_LEN)
                begin
                    ring_bytes[wr_slot][gather_count] = data;
                    gather_count++;
                end
                else
                begin
                    gather_overflow = 1'b1;
                end
                return;
            end
            // overlong block or full ring: one reject, block dropped
            if (gather_overflow || gather_count >= MAX_LEN || advance_slot(wr_slot) == rd_slot)
            begin
                gather_count    = 0;
                gather_overflow = 1'b0;
                rejects_seen++;
                expect_result(ST_PUSH_REJ, 8'h00, 1'b1, 0);
                return;
            end
            ring_bytes[wr_slot][gather_count] = data;
            len = gather_count + 1;
            ring_lengths[wr_slot] = len;
            wr_slot         = advance_slot(wr_slot);
            gather_count    = 0;
            gather_overflow = 1'b0;
            expect_result(ST_PUSH_OK, 8'h00, 1'b1, len);
            return;
        end
        pops_seen++;
        if (rd_slot == wr_slot)
        begin
            expect_result(ST_POP_EMPTY, 8'h00, 1'b1, 0);
            return;
        end
        slot    = rd_slot;
        len     = ring_lengths[slot];
        rd_slot = advance_slot(rd_slot);
        for (i = 0; i < len; i++)
        begin
            expect_result(ST_POP_DATA, ring_bytes[slot][i], i == len - 1, len);
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver: valid stays up until the transaction is taken
    always @(posedge clk or negedge rst_n)
    begin
        req_item_t nxt;
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.action    <= ACT_PUSH;
            req_ch.data_byte <= 8'h00;
            req_ch.last_byte <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_fifo_results(bfl_action_t'(req_ch.action), req_ch.data_byte,
                                     req_ch.last_byte);
                items_accepted++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    nxt = pending_items.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.action    <= nxt.action;
                    req_ch.data_byte <= nxt.data;
                    req_ch.last_byte <= nxt.last;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left    <= 0;
            holds_served <= 0;
        end
        else if (holds_served != holds_requested)
        begin
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        fifo_result_t exp_r;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: status %0d out_byte %0h", rsp_ch.status,
                           rsp_ch.out_byte);
                    errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (rsp_ch.status !== exp_r.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.status, rsp_ch.status);
                        errors++;
                    end
                    if (rsp_ch.out_byte !== exp_r.out_byte)
                    begin
                        $error("out_byte: expected %0h, got %0h", exp_r.out_byte,
                               rsp_ch.out_byte);
                        errors++;
                    end
                    if (rsp_ch.run_last !== exp_r.run_last)
                    begin
                        $error("run_last: expected %0d, got %0d", exp_r.run_last,
                               rsp_ch.run_last);
                        errors++;
                    end
                    if (rsp_ch.block_length !== exp_r.block_length)
                    begin
                        $error("block_length: expected %0d, got %0d", exp_r.block_length,
                               rsp_ch.block_length);
                        errors++;
                    end
                    if (rsp_ch.free_slots !== exp_r.free_slots)
                    begin
                        $error("free_slots: expected %0d, got %0d", exp_r.free_slots,
                               rsp_ch.free_slots);
                        errors++;
                    end
                end
            end
            rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic queue_item(bfl_action_t act, logic [7:0] data, logic last);
        req_item_t it;
        it.action = act;
        it.data   = data;
        it.last   = last;
        pending_items.push_back(it);
    endtask

    // pop carries random data and last, both ignored
    task automatic queue_pop();
        queue_item(ACT_POP, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // block of len bytes; with_pop slips a pop in between two of its bytes
    task automatic queue_block(int len, bit with_pop);
        int i;
        int pop_at;
        pop_at = (with_pop && len > 1) ? $urandom_range(len - 1, 1) : -1;
        for (i = 0; i < len; i++)
        begin
            if (i == pop_at)
            begin
                queue_pop();
            end
            queue_item(ACT_PUSH, 8'($urandom_range(255)), i == len - 1);
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_items.size() != 0 || req_ch.valid || expected_results.size() != 0);
    endtask

    task automatic run_random_phase(int snd_pct, int rcv_pct, int pop_pct, int n_items);
        int start;
        int r;
        int len;
        @(negedge clk);
        sender_idle_pct    = snd_pct;
        receiver_stall_pct = rcv_pct;
        start = items_accepted + pending_items.size();
        while (items_accepted + pending_items.size() - start < n_items)
        begin
            if ($urandom_range(99) < pop_pct)
            begin
                queue_pop();
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 70)
                    len = $urandom_range(6, 1);
                else if (r < 90)
                    len = $urandom_range(30, 7);
                else if (r < 96)
                    len = $urandom_range(MAX_LEN, 31);
                else
                    len = $urandom_range(MAX_LEN + 4, MAX_LEN + 1);
                queue_block(len, $urandom_range(9) == 0);
            end
        end
        wait_drained();
    endtask

    initial
    begin
        int i;
        @(posedge rst_n);
        @(negedge clk);

        // directed corners
        queue_pop();
        queue_item(ACT_PUSH, 8'h00, 1'b1);
        queue_item(ACT_PUSH, 8'hFF, 1'b1);
        queue_item(ACT_POP, 8'hFF, 1'b1);
        queue_item(ACT_POP, 8'h00, 1'b0);
        // pop while a block is half pushed
        queue_item(ACT_PUSH, 8'h5A, 1'b0);
        queue_pop();
        queue_item(ACT_PUSH, 8'hA5, 1'b1);
        queue_pop();
        // longest block that fits, then one that runs past the slot
        queue_block(MAX_LEN, 1'b0);
        queue_block(MAX_LEN + 2, 1'b0);
        queue_pop();
        queue_pop();
        wait_drained();

        // receiver held off while the ring fills past full, then drained
        for (i = 0; i < SLOT_COUNT; i++)
        begin
            queue_pop();
        end
        wait_drained();
        holds_requested = holds_requested + 1;
        for (i = 0; i < SLOT_COUNT + 1; i++)
        begin
            queue_block($urandom_range(3, 1), 1'b0);
        end
        for (i = 0; i < 4; i++)
        begin
            queue_pop();
        end
        wait_drained();

        run_random_phase(0, 0, 30, 22);
        run_random_phase(88, 0, 20, 22);
        run_random_phase(0, 88, 40, 22);
        run_random_phase(28, 28, 30, 22);

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        wait_drained();
        repeat (20) @(negedge clk);

        $display("covered %0d request transactions (%0d pops, %0d rejected pushes), %0d results",
                 items_accepted, pops_seen, rejects_seen, results_checked);
        $display("idling: none, sender, receiver, both, plus a long receiver hold that backs up the input");
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout: %0d results still expected", expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
